### src/rv64i_integer_execute_unit_defines.svh
// Assertion macros shared by the execute unit.
`ifndef RV64I_INTEGER_EXECUTE_UNIT_DEFINES_SVH
`define RV64I_INTEGER_EXECUTE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Holds at every clock edge outside reset.
`define RV64IE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// The consequent is checked with non-overlapping implication after the antecedent sequence ends.
`define RV64IE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RV64IE_ASSERT(label, clk, rst_n, prop, msg)
`define RV64IE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

### src/rv64ie_pkg.sv
package rv64ie_pkg;

    // Operation codes as they arrive on the issue channel.
    typedef enum logic [4:0] {
        OP_ADD   = 5'd0,
        OP_SUB   = 5'd1,
        OP_SLT   = 5'd2,
        OP_SLTU  = 5'd3,
        OP_XOR   = 5'd4,
        OP_OR    = 5'd5,
        OP_AND   = 5'd6,
        OP_SLL   = 5'd7,
        OP_SRL   = 5'd8,
        OP_SRA   = 5'd9,
        OP_ADDW  = 5'd10,
        OP_SUBW  = 5'd11,
        OP_SLLW  = 5'd12,
        OP_SRLW  = 5'd13,
        OP_SRAW  = 5'd14,
        OP_LUI   = 5'd15,
        OP_AUIPC = 5'd16,
        OP_JAL   = 5'd17,
        OP_JALR  = 5'd18,
        OP_BEQ   = 5'd19,
        OP_BNE   = 5'd20,
        OP_BLT   = 5'd21,
        OP_BGE   = 5'd22,
        OP_BLTU  = 5'd23,
        OP_BGEU  = 5'd24
    } op_t;

    localparam logic [63:0] INSN_BYTES   = 64'd4;
    localparam logic [5:0]  SHAMT64_MASK = 6'h3f;
    localparam logic [4:0]  SHAMT32_MASK = 5'h1f;

    // Operands after selection, held in the first stage.
    typedef struct packed {
        op_t         op;
        logic [4:0]  rd;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] imm;
        logic [63:0] pc;
    } opnd_t;

    // Raw unit outputs, held in the second stage.
    typedef struct packed {
        op_t         op;
        logic [4:0]  rd;
        logic [63:0] sum;
        logic [63:0] logic_res;
        logic [63:0] shift_res;
        logic [63:0] pc_imm;
        logic [63:0] pc_seq;
        logic [63:0] jalr_tgt;
        logic [63:0] imm;
        logic        eq;
        logic        lt_s;
        logic        lt_u;
    } exec_t;

    function automatic logic [63:0] sext32(input logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

    function automatic logic is_branch(input op_t op);
        return (op == OP_BEQ) || (op == OP_BNE) || (op == OP_BLT) ||
               (op == OP_BGE) || (op == OP_BLTU) || (op == OP_BGEU);
    endfunction

    function automatic logic is_word(input op_t op);
        return (op == OP_ADDW) || (op == OP_SUBW) || (op == OP_SLLW) ||
               (op == OP_SRLW) || (op == OP_SRAW);
    endfunction

endpackage

### src/rv64ie_if.sv
// Issue channel: one decoded operation per item.
interface rv64ie_issue_if;
    logic               valid;
    logic               ready;
    logic [4:0]         opcode;
    logic               use_imm;
    logic [63:0]        rs1_value;
    logic [63:0]        rs2_value;
    logic signed [31:0] imm;
    logic [63:0]        pc;
    logic [4:0]         rd_index;

    modport source (
        output valid, opcode, use_imm, rs1_value, rs2_value, imm, pc, rd_index,
        input  ready
    );
    modport sink (
        input  valid, opcode, use_imm, rs1_value, rs2_value, imm, pc, rd_index,
        output ready
    );
endinterface

// Result channel: one writeback and next-pc item per operation.
interface rv64ie_result_if;
    logic        valid;
    logic        ready;
    logic [63:0] rd_value;
    logic        rd_write;
    logic [63:0] next_pc;
    logic        branch_taken;

    modport source (
        output valid, rd_value, rd_write, next_pc, branch_taken,
        input  ready
    );
    modport sink (
        input  valid, rd_value, rd_write, next_pc, branch_taken,
        output ready
    );
endinterface

### src/rv64ie_operand.sv
module rv64ie_operand
    import rv64ie_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    rv64ie_issue_if.sink       issue,
    output logic               out_valid,
    input  logic               out_ready,
    output opnd_t              out_data
);

    logic  valid_reg;
    logic  valid_next;
    opnd_t opnd_reg;
    opnd_t opnd_next;
    logic  load;

    // Sign-extend the immediate and pick the second operand. Branches
    // always compare against rs2.
    always_comb
    begin
        opnd_next.op  = op_t'(issue.opcode);
        opnd_next.rd  = issue.rd_index;
        opnd_next.a   = issue.rs1_value;
        opnd_next.imm = sext32(issue.imm);
        opnd_next.pc  = issue.pc;
        if (is_branch(opnd_next.op) || !issue.use_imm)
        begin
            opnd_next.b = issue.rs2_value;
        end
        else
        begin
            opnd_next.b = opnd_next.imm;
        end
    end

    // The stage takes an item when it is empty or its item moves on.
    assign issue.ready = !valid_reg || out_ready;
    assign load        = issue.valid && issue.ready;
    assign valid_next  = issue.ready ? issue.valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            opnd_reg <= opnd_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = opnd_reg;

endmodule

### src/rv64ie_alu.sv
module rv64ie_alu
    import rv64ie_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  opnd_t in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output exec_t out_data
);

    logic        valid_reg;
    logic        valid_next;
    exec_t       exec_reg;
    exec_t       exec_next;
    logic        load;
    logic        sub;
    logic [63:0] b_add;
    logic [5:0]  shamt;
    logic [63:0] ext_a;
    logic [63:0] logic_res;
    logic [63:0] shift_res;

    // Adder, comparators and pc arithmetic work in parallel.
    always_comb
    begin
        sub   = (in_data.op == OP_SUB) || (in_data.op == OP_SUBW);
        b_add = sub ? ~in_data.b : in_data.b;

        exec_next.op        = in_data.op;
        exec_next.rd        = in_data.rd;
        exec_next.imm       = in_data.imm;
        exec_next.sum       = in_data.a + b_add + {63'd0, sub};
        exec_next.logic_res = logic_res;
        exec_next.shift_res = shift_res;
        exec_next.eq        = (in_data.a == in_data.b);
        exec_next.lt_u      = (in_data.a < in_data.b);
        exec_next.lt_s      = ($signed(in_data.a) < $signed(in_data.b));
        exec_next.pc_imm    = in_data.pc + in_data.imm;
        exec_next.pc_seq    = in_data.pc + INSN_BYTES;
        exec_next.jalr_tgt  = (in_data.a + in_data.imm) & ~64'd1;
    end

    // Bitwise logic.
    always_comb
    begin
        case (in_data.op)
            OP_XOR:  logic_res = in_data.a ^ in_data.b;
            OP_OR:   logic_res = in_data.a | in_data.b;
            default: logic_res = in_data.a & in_data.b;
        endcase
    end

    // Barrel shifter. Word forms shift the low word by a 5-bit amount and
    // are sign-extended in the next stage.
    always_comb
    begin
        if (is_word(in_data.op))
        begin
            shamt = {1'b0, in_data.b[4:0] & SHAMT32_MASK};
        end
        else
        begin
            shamt = in_data.b[5:0] & SHAMT64_MASK;
        end
        if (in_data.op == OP_SRAW)
        begin
            ext_a = sext32(in_data.a[31:0]);
        end
        else
        begin
            ext_a = {32'd0, in_data.a[31:0]};
        end
        case (in_data.op)
            OP_SLL, OP_SLLW: shift_res = in_data.a << shamt;
            OP_SRL:          shift_res = in_data.a >> shamt;
            OP_SRLW:         shift_res = ext_a >> shamt;
            OP_SRA:          shift_res = $signed(in_data.a) >>> shamt;
            OP_SRAW:         shift_res = $signed(ext_a) >>> shamt;
            default:         shift_res = 64'd0;
        endcase
    end

    assign in_ready   = !valid_reg || out_ready;
    assign load       = in_valid && in_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            exec_reg <= exec_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = exec_reg;

endmodule

### src/rv64ie_writeback.sv
module rv64ie_writeback
    import rv64ie_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  exec_t           in_data,
    rv64ie_result_if.source result
);

    logic        valid_reg;
    logic        valid_next;
    logic [63:0] rd_value_reg;
    logic [63:0] rd_value_next;
    logic        rd_write_reg;
    logic        rd_write_next;
    logic [63:0] next_pc_reg;
    logic [63:0] next_pc_next;
    logic        taken_reg;
    logic        taken_next;
    logic        writes;
    logic        cond;
    logic        load;

    // Pick the destination value and resolve control flow.
    always_comb
    begin
        rd_value_next = 64'd0;
        next_pc_next  = in_data.pc_seq;
        writes        = 1'b1;
        taken_next    = 1'b0;
        cond          = 1'b0;
        case (in_data.op)
            OP_ADD, OP_SUB:            rd_value_next = in_data.sum;
            OP_SLT:                    rd_value_next = {63'd0, in_data.lt_s};
            OP_SLTU:                   rd_value_next = {63'd0, in_data.lt_u};
            OP_XOR, OP_OR, OP_AND:     rd_value_next = in_data.logic_res;
            OP_SLL, OP_SRL, OP_SRA:    rd_value_next = in_data.shift_res;
            OP_ADDW, OP_SUBW:          rd_value_next = sext32(in_data.sum[31:0]);
            OP_SLLW, OP_SRLW, OP_SRAW: rd_value_next = sext32(in_data.shift_res[31:0]);
            OP_LUI:                    rd_value_next = in_data.imm;
            OP_AUIPC:                  rd_value_next = in_data.pc_imm;
            OP_JAL:
            begin
                rd_value_next = in_data.pc_seq;
                next_pc_next  = in_data.pc_imm;
                taken_next    = 1'b1;
            end
            OP_JALR:
            begin
                rd_value_next = in_data.pc_seq;
                next_pc_next  = in_data.jalr_tgt;
                taken_next    = 1'b1;
            end
            OP_BEQ, OP_BNE, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU:
            begin
                writes = 1'b0;
                case (in_data.op)
                    OP_BEQ:  cond = in_data.eq;
                    OP_BNE:  cond = !in_data.eq;
                    OP_BLT:  cond = in_data.lt_s;
                    OP_BGE:  cond = !in_data.lt_s;
                    OP_BLTU: cond = in_data.lt_u;
                    default: cond = !in_data.lt_u;
                endcase
                taken_next = cond;
                if (cond)
                begin
                    next_pc_next = in_data.pc_imm;
                end
            end
            default: writes = 1'b0;
        endcase
        rd_write_next = writes && (in_data.rd != 5'd0);
    end

    // Output register; it also takes a new item while the consumer reads.
    assign in_ready   = !valid_reg || result.ready;
    assign load       = in_valid && in_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rd_value_reg <= rd_value_next;
            rd_write_reg <= rd_write_next;
            next_pc_reg  <= next_pc_next;
            taken_reg    <= taken_next;
        end
    end

    assign result.valid        = valid_reg;
    assign result.rd_value     = rd_value_reg;
    assign result.rd_write     = rd_write_reg;
    assign result.next_pc      = next_pc_reg;
    assign result.branch_taken = taken_reg;

endmodule

### src/rv64i_integer_execute_unit.sv
// RV64I integer execute unit: three register stages (operand select, compute, writeback).
// An accepted issue item moves through the operand, compute and writeback registers in order.
// Throughput is one item per cycle while the consumer is ready; a stall holds up to three items.
// Reset (rst_n, asynchronous, active low) clears the valid bits of all stages; data is not reset.
`include "rv64i_integer_execute_unit_defines.svh"

module rv64i_integer_execute_unit
    import rv64ie_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    rv64ie_issue_if.sink    issue,
    rv64ie_result_if.source result
);

    logic  opnd_valid;
    logic  opnd_ready;
    opnd_t opnd_data;
    logic  exec_valid;
    logic  exec_ready;
    exec_t exec_data;

    // Stage one: operand selection.
    rv64ie_operand u_operand (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue     (issue),
        .out_valid (opnd_valid),
        .out_ready (opnd_ready),
        .out_data  (opnd_data)
    );

    // Stage two: adder, comparators, logic and shifter.
    rv64ie_alu u_alu (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (opnd_valid),
        .in_ready  (opnd_ready),
        .in_data   (opnd_data),
        .out_valid (exec_valid),
        .out_ready (exec_ready),
        .out_data  (exec_data)
    );

    // Stage three: result selection and output register.
    rv64ie_writeback u_writeback (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (exec_valid),
        .in_ready (exec_ready),
        .in_data  (exec_data),
        .result   (result)
    );

    // An empty output stage means the whole pipeline can take an item.
    `RV64IE_ASSERT(a_ready_when_drained, clk, rst_n,
        issue.ready || result.valid, "issue stalled with empty output")
    // With the consumer ready, an accepted item passes the compute and writeback registers to the output.
    `RV64IE_ASSERT_NEXT(a_latency, clk, rst_n,
        (issue.valid && issue.ready) ##1 result.ready ##1 result.ready,
        result.valid, "item did not arrive in three cycles")

endmodule
